>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PFA_ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfa assertion failed");

// checked at every edge, reset included
`define PFA_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pfa assertion failed");

`endif

>>> src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Widths, request and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W      = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int PFN_W       = ADDR_W - PAGE_SHIFT;
    localparam int CNT_W       = 13;
    localparam int REF_W       = 8;
    localparam int REQ_W       = 2;
    localparam int ST_W        = 2;
    localparam int FRAMES_DEF  = 4096;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

    localparam logic [REQ_W-1:0] REQ_ALLOC_ONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_RUN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE      = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [ST_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD    = 2'd3;

endpackage

>>> src/pfa_ifs.sv
// ----------------------------------------------------------------------------
// Page frame allocator channels
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  page_count;

    modport source (output valid, req_type, address, page_count, input ready);
    modport sink   (input valid, req_type, address, page_count, output ready);
endinterface

interface pfa_res_if import pfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] page_address;

    modport source (output valid, status, page_address, input ready);
    modport sink   (input valid, status, page_address, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] low_mem_base;

    modport source (output valid, low_mem_base, input ready);
    modport sink   (input valid, low_mem_base, output ready);
endinterface

>>> src/pfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// Page frame allocator
// Keeps one reference count per 4 KiB frame in a RAM and serves allocate
// one / allocate run / free run requests, one result beat per request.
// i_req: request beats; o_res: status and page address; i_cfg: writes the
// base address of frame zero (reset 0x0010_0000), taken only when idle.
// After reset a clearing pass zeroes the count RAM, one entry a cycle,
// with i_req.ready low throughout.
// One request at a time. Allocations walk the count RAM downward from the
// top frame, one entry a cycle, then write the run. A free walks the run
// read-modify-write at one frame a cycle. The count RAM port is the limit
// throughout. The result sits in an output register; the next request is
// taken while it waits, and a stalled receiver holds the block only once
// its next result is ready.
// ----------------------------------------------------------------------------
module page_frame_allocator_top import pfa_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfa_req_if.sink    i_req,
    pfa_res_if.source  o_res,
    pfa_cfg_if.sink    i_cfg
);

    localparam int IW = $clog2(FRAMES);
    localparam logic [IW-1:0]  LAST_IDX = IW'(FRAMES - 1);
    localparam logic [IW-1:0]  NEXT_IDX = IW'(FRAMES - 2);
    localparam logic [PFN_W:0] FR_EXT   = (PFN_W + 1)'(FRAMES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_base;
    logic [IW-1:0]     r_clr_idx, n_clr_idx;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    logic [REQ_W-1:0]  r_type, n_type;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]     r_next_idx, n_next_idx;
    logic [IW-1:0]     r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [IW-1:0]     r_fill_idx, n_fill_idx;
    logic [IW-1:0]     r_found_idx, n_found_idx;
    logic              r_dbl, n_dbl;
    logic [ST_W-1:0]   r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [ST_W-1:0]   r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;

    logic              ram_wr_en, ram_rd_en;
    logic [IW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [REF_W-1:0]  ram_wr_data, ram_rd_data;

    // free range check
    logic [ADDR_W-1:0] diff;
    logic [PFN_W:0]    p_ext, rem;
    logic              free_bad;
    logic [CNT_W-1:0]  run_inc;
    logic [ADDR_W-1:0] found_addr;

    assign diff     = r_addr - r_base;
    assign p_ext    = {1'b0, diff[ADDR_W-1:PAGE_SHIFT]};
    assign rem      = FR_EXT - p_ext;
    assign free_bad = (r_cnt == '0) || (r_addr < r_base) || (p_ext >= FR_EXT)
                      || ((PFN_W + 1)'(r_cnt) > rem);
    assign run_inc    = r_run + 1'b1;
    assign found_addr = r_base + (ADDR_W'(r_found_idx) << PAGE_SHIFT);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.page_address = r_out_addr;

    pfa_ram #(
        .WIDTH (REF_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid & ~o_res.ready;
        n_type       = r_type;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_next_idx   = r_next_idx;
        n_pend_idx   = r_pend_idx;
        n_run        = r_run;
        n_left       = r_left;
        n_fill_idx   = r_fill_idx;
        n_found_idx  = r_found_idx;
        n_dbl        = r_dbl;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_pend_idx;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_next_idx;

        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_idx;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type  = i_req.req_type;
                    n_addr  = i_req.address;
                    n_cnt   = i_req.page_count;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_addr = '0;
                n_pend     = 1'b0;
                case (r_type)
                    REQ_ALLOC_ONE, REQ_ALLOC_RUN: begin
                        if (r_type == REQ_ALLOC_RUN && r_cnt == '0) begin
                            n_res_status = ST_BAD;
                            n_state      = S_DONE;
                        end else begin
                            if (r_type == REQ_ALLOC_ONE) begin
                                n_cnt = CNT_W'(1);
                            end
                            // top frame read goes out now
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = LAST_IDX;
                            n_pend      = 1'b1;
                            n_pend_idx  = LAST_IDX;
                            n_next_idx  = NEXT_IDX;
                            n_run       = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    REQ_FREE: begin
                        if (free_bad) begin
                            n_res_status = ST_BAD;
                            n_state      = S_DONE;
                        end else begin
                            n_next_idx = p_ext[IW-1:0];
                            n_left     = r_cnt;
                            n_dbl      = 1'b0;
                            n_state    = S_FREE;
                        end
                    end
                    default: begin
                        n_res_status = ST_BAD;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_pend && ram_rd_data == '0 && run_inc == r_cnt) begin
                    n_found_idx = r_pend_idx;
                    n_fill_idx  = r_pend_idx;
                    n_left      = r_cnt;
                    n_pend      = 1'b0;
                    n_state     = S_FILL;
                end else begin
                    if (r_pend) begin
                        n_run = (ram_rd_data == '0) ? run_inc : '0;
                    end
                    // frame zero is never read
                    if (r_next_idx != '0) begin
                        ram_rd_en  = 1'b1;
                        n_pend     = 1'b1;
                        n_pend_idx = r_next_idx;
                        n_next_idx = r_next_idx - 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_res_status = ST_NOFREE;
                            n_res_addr   = '0;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_fill_idx;
                ram_wr_data = REF_W'(1);
                n_fill_idx  = r_fill_idx + 1'b1;
                n_left      = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_res_status = ST_OK;
                    n_res_addr   = found_addr;
                    n_state      = S_DONE;
                end
            end
            S_FREE: begin
                // write back frame k while frame k+1 is read
                if (r_pend) begin
                    if (ram_rd_data == '0) begin
                        n_dbl = 1'b1;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data - REF_W'(1);
                    end
                end
                if (r_left != '0) begin
                    ram_rd_en  = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_next_idx;
                    n_next_idx = r_next_idx + 1'b1;
                    n_left     = r_left - 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_res_status = r_dbl ? ST_DOUBLE : ST_OK;
                        n_res_addr   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_base <= i_cfg.low_mem_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type       <= n_type;
        r_addr       <= n_addr;
        r_cnt        <= n_cnt;
        r_next_idx   <= n_next_idx;
        r_pend_idx   <= n_pend_idx;
        r_run        <= n_run;
        r_left       <= n_left;
        r_fill_idx   <= n_fill_idx;
        r_found_idx  <= n_found_idx;
        r_dbl        <= n_dbl;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

endmodule

>>> src/pfa_checker.sv
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Port-level assertions on the result channel and the clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfa_checker import pfa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [ST_W-1:0]   i_res_status,
    input logic [ADDR_W-1:0] i_res_page_address
);

    // a result beat holds until taken
    `PFA_ASSERT_RUN(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid)

    `PFA_ASSERT_RUN(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> $stable(i_res_status) && $stable(i_res_page_address))

    // a failed request never hands out an address
    `PFA_ASSERT_RUN(a_fail_zero, i_clk, i_rst_n, i_res_valid && (i_res_status != ST_OK) |-> i_res_page_address == '0)

    // clearing pass: no request taken right after reset
    `PFA_ASSERT_ALL(a_clear_block, i_clk, !i_rst_n |=> !i_req_ready)

endmodule

bind page_frame_allocator_top pfa_checker u_pfa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_ready        (i_req.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_status       (o_res.status),
    .i_res_page_address (o_res.page_address)
);
